// ===== src/rsf_pkg.sv =====
// Package: shared constants, command codes and controller/datapath link types.
`timescale 1ns / 1ps
package rsf_pkg;

  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned TAG_BITS = 8;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned RNUM_W   = 5;
  localparam int unsigned ITAG_W   = 8;
  localparam int unsigned VAL_W    = 64;

  localparam int unsigned IN_DW    = 88;
  localparam int unsigned OUT_DW   = 128;

  typedef enum logic [CMD_W-1:0] {
    CMD_ISSUE    = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_RETIRE   = 2'd2,
    CMD_FLUSH    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic cap;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_room;
  } dp_stat_t;

endpackage

// ===== src/register_scoreboard_forwarding_top.sv =====
// Top level: register file scoreboard with operand forwarding.
//
//   port group   dir  tdata fields (low bit up)                          tuser
//   in_          in   source_one, source_two, dest_reg, inst_tag,        command
//                     write_value, 1 pad bit
//   out_         out  source_one_value, source_two_value                 stall_res
//
// Each word: the accept edge in the idle state launches the registered file,
// forward and tag reads; the exec state commits scoreboard and file updates.
// The next word is accepted while a finished result waits in the output
// register; a stalled output holds the controller in its commit state.
// Reset clears the scoreboard, register valid bits and the output valid flag.
`timescale 1ns / 1ps
module register_scoreboard_forwarding_top
  import rsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // source_one, source_two, dest_reg, inst_tag, write_value
  input  logic [CMD_W-1:0]  in_tuser,   // command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // source_one_value, source_two_value
  output logic              out_tuser   // stall_res
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  rsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  rsf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== src/rsf_ctrl.sv =====
// Controller: sequences capture and commit of one command word at a time.
`timescale 1ns / 1ps
module rsf_ctrl
  import rsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    ctl.cap    = 1'b0;
    ctl.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.cap   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_room) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  property p_cap_only_idle;
    @(posedge clk) disable iff (!rst_n) ctl.cap |-> state_r == ST_IDLE && !ctl.commit;
  endproperty
  a_cap_only_idle: assert property (p_cap_only_idle) else $error("capture outside idle");

endmodule

// ===== src/rsf_datapath.sv =====
// Datapath: register file, scoreboard, forward store and result register.
`timescale 1ns / 1ps
module rsf_datapath
  import rsf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            ctl,
  output dp_stat_t            stat,
  input  logic [CMD_W-1:0]    in_tuser,
  input  logic [IN_DW-1:0]    in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_tuser,
  output logic [OUT_DW-1:0]   out_tdata
);

  logic [VAL_W-1:0]    reg_mem [NUM_REGS];
  logic [VAL_W-1:0]    fwd_mem [NUM_REGS];
  logic [TAG_BITS-1:0] tag_mem [NUM_REGS];

  logic [NUM_REGS-1:0] reg_vld_r,  reg_vld_nxt;
  logic [NUM_REGS-1:0] prod_vld_r, prod_vld_nxt;
  logic [NUM_REGS-1:0] prod_rdy_r, prod_rdy_nxt;

  cmd_t                cmd_r;
  logic [RNUM_W-1:0]   rs1_r, rs2_r, rd_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [VAL_W-1:0]    val_r;

  logic [VAL_W-1:0]    reg1_q, reg2_q, fwd1_q, fwd2_q;
  logic [TAG_BITS-1:0] tag_q;

  logic                out_vld_r;
  logic                out_user_r;
  logic [OUT_DW-1:0]   out_data_r;

  logic [RNUM_W-1:0]   in_rs1, in_rs2, in_rd;
  logic [REG_AW-1:0]   i1, i2, id;
  logic                ok1, ok2, rd_ok;
  logic                s1, s2, stall;
  logic [VAL_W-1:0]    v1, v2;
  logic [TAG_BITS-1:0] eff_tag;
  logic                tag_hit;
  logic                we_reg, we_fwd, we_tag;

  assign in_rs1 = in_tdata[4:0];
  assign in_rs2 = in_tdata[9:5];
  assign in_rd  = in_tdata[14:10];

  // capture the word and launch the registered reads
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_r  <= cmd_t'(in_tuser);
      rs1_r  <= in_rs1;
      rs2_r  <= in_rs2;
      rd_r   <= in_rd;
      tag_r  <= TAG_BITS'(in_tdata[22:15]);
      val_r  <= in_tdata[86:23];
      reg1_q <= reg_mem[REG_AW'(in_rs1)];
      reg2_q <= reg_mem[REG_AW'(in_rs2)];
      fwd1_q <= fwd_mem[REG_AW'(in_rs1)];
      fwd2_q <= fwd_mem[REG_AW'(in_rs2)];
      tag_q  <= tag_mem[REG_AW'(in_rd)];
    end
  end

  assign i1    = REG_AW'(rs1_r);
  assign i2    = REG_AW'(rs2_r);
  assign id    = REG_AW'(rd_r);
  assign ok1   = (rs1_r != '0) && (32'(rs1_r) < NUM_REGS);
  assign ok2   = (rs2_r != '0) && (32'(rs2_r) < NUM_REGS);
  assign rd_ok = (rd_r != '0) && (32'(rd_r) < NUM_REGS);

  always_comb begin
    s1 = 1'b0;
    v1 = '0;
    if (ok1) begin
      if (prod_vld_r[i1]) begin
        if (prod_rdy_r[i1]) v1 = fwd1_q;
        else                s1 = 1'b1;
      end else if (reg_vld_r[i1]) begin
        v1 = reg1_q;
      end
    end
    s2 = 1'b0;
    v2 = '0;
    if (ok2) begin
      if (prod_vld_r[i2]) begin
        if (prod_rdy_r[i2]) v2 = fwd2_q;
        else                s2 = 1'b1;
      end else if (reg_vld_r[i2]) begin
        v2 = reg2_q;
      end
    end
  end

  assign stall   = s1 || s2;
  assign eff_tag = prod_vld_r[id] ? tag_q : '0;
  assign tag_hit = (eff_tag == tag_r);

  always_comb begin
    reg_vld_nxt  = reg_vld_r;
    prod_vld_nxt = prod_vld_r;
    prod_rdy_nxt = prod_rdy_r;
    we_reg       = 1'b0;
    we_fwd       = 1'b0;
    we_tag       = 1'b0;
    if (ctl.commit) begin
      case (cmd_r)
        CMD_ISSUE: begin
          if (!stall && rd_ok) begin
            we_tag           = 1'b1;
            prod_vld_nxt[id] = (tag_r != '0);
            prod_rdy_nxt[id] = 1'b0;
          end
        end
        CMD_COMPLETE: begin
          if (rd_ok && tag_r != '0 && tag_hit) begin
            we_fwd           = 1'b1;
            prod_rdy_nxt[id] = 1'b1;
          end
        end
        CMD_RETIRE: begin
          if (rd_ok) begin
            we_reg          = 1'b1;
            reg_vld_nxt[id] = 1'b1;
            if (tag_hit) begin
              prod_vld_nxt[id] = 1'b0;
              prod_rdy_nxt[id] = 1'b0;
            end
          end
        end
        CMD_FLUSH: begin
          prod_vld_nxt = '0;
          prod_rdy_nxt = '0;
        end
        default: begin
          prod_vld_nxt = prod_vld_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we_reg) reg_mem[id] <= val_r;
    if (we_fwd) fwd_mem[id] <= val_r;
    if (we_tag) tag_mem[id] <= tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r  <= '0;
      prod_vld_r <= '0;
      prod_rdy_r <= '0;
    end else begin
      reg_vld_r  <= reg_vld_nxt;
      prod_vld_r <= prod_vld_nxt;
      prod_rdy_r <= prod_rdy_nxt;
    end
  end

  // result register; a held word frees up when taken
  assign stat.out_room = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.commit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (cmd_r == CMD_ISSUE) begin
        out_user_r <= stall;
        out_data_r <= {v2, v1};
      end else begin
        out_user_r <= 1'b0;
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  property p_rdy_needs_prod;
    @(posedge clk) disable iff (!rst_n) (prod_rdy_r & ~prod_vld_r) == '0;
  endproperty
  a_rdy_needs_prod: assert property (p_rdy_needs_prod) else $error("ready without producer");

  property p_flush_clears;
    @(posedge clk) disable iff (!rst_n)
      ctl.commit && cmd_r == CMD_FLUSH |=> prod_vld_r == '0 && prod_rdy_r == '0;
  endproperty
  a_flush_clears: assert property (p_flush_clears) else $error("flush left a producer");

  property p_non_issue_zero;
    @(posedge clk) disable iff (!rst_n)
      ctl.commit && cmd_r != CMD_ISSUE |=> !out_tuser && out_tdata == '0;
  endproperty
  a_non_issue_zero: assert property (p_non_issue_zero) else $error("nonzero non-issue result");

  property p_stall_keeps_sb;
    @(posedge clk) disable iff (!rst_n)
      ctl.commit && cmd_r == CMD_ISSUE && stall |=> $stable(prod_vld_r) && $stable(prod_rdy_r);
  endproperty
  a_stall_keeps_sb: assert property (p_stall_keeps_sb) else $error("stalled issue changed scoreboard");

endmodule

// ===== sim/tb_register_scoreboard_forwarding_top.sv =====
// Testbench: streams scoreboard commands into the block and checks each result word.
`timescale 1ns / 1ps
module tb_register_scoreboard_forwarding_top;
  import rsf_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    logic        stall;
    logic [63:0] op_one;
    logic [63:0] op_two;
  } operand_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [CMD_W-1:0]  in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;

  logic [63:0]         file_val [NUM_REGS];
  logic [TAG_BITS-1:0] sb_tag   [NUM_REGS];
  logic                sb_ready [NUM_REGS];
  logic [63:0]         sb_fwd   [NUM_REGS];

  operand_t operand_q[$];
  int       errors;
  int       idle_cycles;
  bit       tx_gaps;
  bit       rx_gaps;
  bit       hold_pending;

  register_scoreboard_forwarding_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int pick_gap(input bit enable);
    int r;
    r = $urandom_range(0, 99);
    if (!enable || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic read_operand(input logic [4:0] num, output logic [63:0] v);
    v = '0;
    if (num == 0 || num >= NUM_REGS) return 1'b0;
    if (sb_tag[num] != 0) begin
      if (sb_ready[num]) begin
        v = sb_fwd[num];
        return 1'b0;
      end
      return 1'b1;
    end
    v = file_val[num];
    return 1'b0;
  endfunction

  function automatic operand_t apply_command(input cmd_t cmd, input logic [4:0] rs1,
                                             input logic [4:0] rs2, input logic [4:0] rd,
                                             input logic [7:0] tag_in, input logic [63:0] val);
    operand_t            res;
    logic                s1;
    logic                s2;
    logic [TAG_BITS-1:0] tag;
    logic                rd_ok;
    res.stall  = 1'b0;
    res.op_one = '0;
    res.op_two = '0;
    tag   = tag_in[TAG_BITS-1:0];
    rd_ok = rd != 0 && rd < NUM_REGS;
    case (cmd)
      CMD_ISSUE: begin
        s1 = read_operand(rs1, res.op_one);
        s2 = read_operand(rs2, res.op_two);
        res.stall = s1 | s2;
        if (!res.stall && rd_ok) begin
          sb_tag[rd]   = tag;
          sb_ready[rd] = 1'b0;
        end
      end
      CMD_COMPLETE: begin
        if (rd_ok && tag != 0 && sb_tag[rd] == tag) begin
          sb_ready[rd] = 1'b1;
          sb_fwd[rd]   = val;
        end
      end
      CMD_RETIRE: begin
        if (rd_ok) begin
          file_val[rd] = val;
          if (sb_tag[rd] == tag) begin
            sb_tag[rd]   = '0;
            sb_ready[rd] = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < NUM_REGS; i++) begin
          sb_tag[i]   = '0;
          sb_ready[i] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_word(input cmd_t cmd, input logic [4:0] rs1, input logic [4:0] rs2,
                           input logic [4:0] rd, input logic [7:0] tag,
                           input logic [63:0] val);
    int gap;
    gap = pick_gap(tx_gaps);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, tag, rd, rs2, rs1};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    operand_q.push_back(apply_command(cmd, rs1, rs2, rd, tag, val));
  endtask

  function automatic logic [4:0] rand_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 5'd0;
    if (r < 20) return 5'd31;
    if (r < 75) return 5'($urandom_range(1, 4));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 19))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random_word();
    int          r;
    logic [4:0]  rd;
    logic [7:0]  tag;
    r  = $urandom_range(0, 99);
    rd = rand_reg();
    if (r < 5) begin
      send_word(cmd_t'($urandom_range(0, 3)), 5'($urandom), 5'($urandom), 5'($urandom),
                8'($urandom), {$urandom, $urandom});
    end else if (r < 50) begin
      tag = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      send_word(CMD_ISSUE, rand_reg(), rand_reg(), rd, tag, rand_value());
    end else if (r < 97) begin
      tag = ($urandom_range(0, 3) != 0) ? 8'(sb_tag[rd]) : 8'($urandom);
      send_word((r < 75) ? CMD_COMPLETE : CMD_RETIRE, rand_reg(), rand_reg(), rd, tag,
                rand_value());
    end else begin
      send_word(CMD_FLUSH, rand_reg(), rand_reg(), rd, 8'($urandom), rand_value());
    end
  endtask

  task automatic run_reset_reads();
    send_word(CMD_ISSUE, 5'd0, 5'd0, 5'd0, 8'd0, '0);
    send_word(CMD_ISSUE, 5'd31, 5'd1, 5'd0, 8'd0, '0);
  endtask

  task automatic run_retire_extremes();
    send_word(CMD_RETIRE, 5'd0, 5'd0, 5'd31, 8'd0, 64'h8000_0000_0000_0000);
    send_word(CMD_RETIRE, 5'd0, 5'd0, 5'd1, 8'd0, 64'h7fff_ffff_ffff_ffff);
    send_word(CMD_RETIRE, 5'd0, 5'd0, 5'd0, 8'd0, '1);
    send_word(CMD_ISSUE, 5'd31, 5'd1, 5'd0, 8'd0, '0);
  endtask

  task automatic run_forwarding();
    send_word(CMD_ISSUE, 5'd0, 5'd0, 5'd5, 8'd255, '0);
    send_word(CMD_ISSUE, 5'd5, 5'd31, 5'd8, 8'd11, '0);
    send_word(CMD_COMPLETE, 5'd0, 5'd0, 5'd5, 8'd7, 64'h1234_5678_9abc_def0);
    send_word(CMD_COMPLETE, 5'd0, 5'd0, 5'd5, 8'd255, '1);
    send_word(CMD_ISSUE, 5'd5, 5'd8, 5'd0, 8'd0, '0);
    send_word(CMD_ISSUE, 5'd0, 5'd0, 5'd5, 8'd0, '0);
    send_word(CMD_ISSUE, 5'd5, 5'd5, 5'd0, 8'd0, '0);
  endtask

  task automatic run_flush_and_tags();
    send_word(CMD_ISSUE, 5'd0, 5'd0, 5'd6, 8'd1, '0);
    send_word(CMD_COMPLETE, 5'd0, 5'd0, 5'd6, 8'd0, 64'h5555_5555_5555_5555);
    send_word(CMD_RETIRE, 5'd0, 5'd0, 5'd6, 8'd2, 64'haaaa_aaaa_aaaa_aaaa);
    send_word(CMD_ISSUE, 5'd1, 5'd6, 5'd0, 8'd0, '0);
    send_word(CMD_FLUSH, 5'd0, 5'd0, 5'd0, 8'd0, '0);
    send_word(CMD_ISSUE, 5'd1, 5'd6, 5'd0, 8'd0, '0);
    send_word(CMD_ISSUE, 5'd0, 5'd0, 5'd7, 8'd3, '0);
    send_word(CMD_COMPLETE, 5'd0, 5'd0, 5'd7, 8'd3, 64'h0123_4567_89ab_cdef);
    send_word(CMD_ISSUE, 5'd0, 5'd0, 5'd7, 8'd4, '0);
    send_word(CMD_ISSUE, 5'd7, 5'd31, 5'd0, 8'd0, '0);
    send_word(CMD_RETIRE, 5'd0, 5'd0, 5'd7, 8'd4, 64'hfedc_ba98_7654_3210);
    send_word(CMD_ISSUE, 5'd7, 5'd0, 5'd0, 8'd0, '0);
  endtask

  task automatic run_random_pipeline(input int count);
    repeat (count) send_random_word();
  endtask

  task automatic run_output_hold();
    tx_gaps      = 1'b0;
    hold_pending = 1'b1;
    repeat (40) send_random_word();
    while (hold_pending) @(posedge clk);
    tx_gaps = 1'b1;
  endtask

  task automatic run_full_rate();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (60) send_random_word();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      if (hold_pending) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else begin
        n = pick_gap(rx_gaps);
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    operand_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (operand_q.size() == 0) begin
        $display("%0t: unexpected result word stall=%0b tdata=%h", $time, out_tuser,
                 out_tdata);
        errors++;
      end else begin
        want = operand_q.pop_front();
        if (out_tuser !== want.stall) begin
          $display("%0t: stall_res expected %0b actual %0b", $time, want.stall, out_tuser);
          errors++;
        end
        if (out_tdata[63:0] !== want.op_one) begin
          $display("%0t: source_one_value expected %h actual %h", $time, want.op_one,
                   out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== want.op_two) begin
          $display("%0t: source_two_value expected %h actual %h", $time, want.op_two,
                   out_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("register_scoreboard_forwarding_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = CMD_ISSUE;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_pending = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) begin
      file_val[i] = '0;
      sb_tag[i]   = '0;
      sb_ready[i] = 1'b0;
      sb_fwd[i]   = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_reset_reads();
    run_retire_extremes();
    run_forwarding();
    run_flush_and_tags();
    run_random_pipeline(380);
    run_output_hold();
    run_full_rate();

    in_tvalid <= 1'b0;
    while (operand_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("register_scoreboard_forwarding_top verification clean");
    end else begin
      $display("register_scoreboard_forwarding_top verification failed");
    end
    $finish;
  end

endmodule
